>>> hw/rtl/bss_pkg.sv
package bss_pkg;

  // fixed field widths
  localparam int CMD_W    = 4;
  localparam int DATA_W   = 8;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 6;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_POP       = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_REPLACE   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_READ      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DUMP_UP   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DUMP_DOWN = 4'd9;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd3;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  // per-cell shift and compare controls
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              load;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

>>> hw/rtl/bss_if.sv
interface bss_req_if;
  logic                          valid;
  logic                          ready;
  logic [bss_pkg::CMD_W-1:0]     command;
  logic [bss_pkg::DATA_W-1:0]    value;
  logic [bss_pkg::POS_W-1:0]     position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface bss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bss_pkg::DATA_W-1:0]    data;
  logic                          found;
  logic [bss_pkg::CNT_W-1:0]     count;
  logic [bss_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, data, found, count, status, last, input ready);
  modport sink   (input valid, data, found, count, status, last, output ready);
endinterface

>>> hw/rtl/bss_cell.sv
module bss_cell (
  input  logic                       clk,
  input  bss_pkg::cell_ctl_t         ctl,
  input  logic                       live,
  input  logic [bss_pkg::DATA_W-1:0] from_up,
  input  logic [bss_pkg::DATA_W-1:0] from_dn,
  output logic [bss_pkg::DATA_W-1:0] data,
  output logic                       hit
);
  import bss_pkg::*;

  // shift toward bottom on push, toward top on pop, overwrite on replace
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= from_up;
    end else if (ctl.pop) begin
      data <= from_dn;
    end else if (ctl.load) begin
      data <= ctl.value;
    end
  end

  // local match against the search key
  assign hit = live && (data == ctl.value);

endmodule

>>> hw/rtl/byte_stack_with_search.sv
// channel  | dir | payload                              | notes
// req      | in  | command, value, position             | one command per beat
// rsp      | out | data, found, count, status, last     | last marks final beat
//
// a non-dump command's result is registered at the accept edge
// dump of N entries: N beats via cell row mux, one per cycle unless rsp stalls;
// no new command is taken until the final dump beat is loaded
// rst is synchronous: clears the fill count, sequencer and result valid
// a stalled rsp holds its beat; req is accepted while the held beat is taken
module byte_stack_with_search #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  bss_req_if.sink   req,
  bss_rsp_if.source rsp
);
  import bss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int W  = (CW > POS_W) ? CW : POS_W;

  state_t state, state_next;

  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     k;
  logic              dir_up;
  logic [DATA_W-1:0] cd [DEPTH];
  logic [DEPTH-1:0]  hits;

  logic slot_free, accept, dump_emit;
  logic do_push, do_pop, do_load, start_dump;
  logic empty, full;

  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic              out_found;
  logic [CNT_W-1:0]  out_count;
  logic [STATUS_W-1:0] out_status;
  logic              out_last;

  logic [DATA_W-1:0]   r_data;
  logic                r_found;
  logic [STATUS_W-1:0] r_status;
  logic                r_last;

  logic [CW-1:0] beat_k, dump_pos;
  logic          up, dump_last, bad_pos;
  logic [W-1:0]  read_diff;
  logic [IW-1:0] rd_sel;
  logic [DATA_W-1:0] rd_data;

  assign empty = (cnt == '0);
  assign full  = (cnt == CW'(DEPTH));

  // row of cells, top of stack in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t               ctl;
    logic [DATA_W-1:0]       up_in, dn_in;

    assign ctl.push  = do_push;
    assign ctl.pop   = do_pop;
    assign ctl.value = req.value;

    if (i == 0) begin : g_top
      assign ctl.load = do_load;
      assign up_in    = req.value;
    end else begin : g_mid
      assign ctl.load = 1'b0;
      assign up_in    = cd[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign dn_in = '0;
    end else begin : g_inner
      assign dn_in = cd[i+1];
    end

    bss_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .live    (CW'(i) < cnt),
      .from_up (up_in),
      .from_dn (dn_in),
      .data    (cd[i]),
      .hit     (hits[i])
    );
  end

  // read select: dump beat index or position from the bottom
  assign beat_k    = (state == ST_DUMP) ? k : '0;
  assign up        = (state == ST_DUMP) ? dir_up : (req.command == CMD_DUMP_UP);
  assign dump_pos  = up ? CW'(cnt - CW'(1) - beat_k) : beat_k;
  assign dump_last = (CW'(beat_k + CW'(1)) == cnt);
  assign read_diff = W'(cnt) - W'(req.position);
  assign bad_pos   = (req.position == '0) || (W'(req.position) > W'(cnt));
  assign rd_sel    = (state == ST_IDLE && req.command == CMD_READ) ?
                     read_diff[IW-1:0] : dump_pos[IW-1:0];
  assign rd_data   = cd[rd_sel];

  // sequencer outputs
  assign slot_free = !out_valid || rsp.ready;
  always_comb begin
    req.ready = 1'b0;
    dump_emit = 1'b0;
    case (state)
      ST_IDLE: req.ready = slot_free;
      ST_DUMP: dump_emit = slot_free;
      default: begin
        req.ready = 1'b0;
        dump_emit = 1'b0;
      end
    endcase
  end
  assign accept = req.valid && req.ready;

  // command decode
  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_load    = 1'b0;
    start_dump = 1'b0;
    cnt_next   = cnt;
    r_data     = '0;
    r_found    = 1'b0;
    r_status   = STAT_OK;
    r_last     = 1'b1;
    case (req.command)
      CMD_PUSH: begin
        if (full) begin
          r_status = STAT_FULL;
        end else begin
          do_push  = accept;
          cnt_next = CW'(cnt + CW'(1));
        end
      end
      CMD_POP: begin
        if (empty) begin
          r_status = STAT_EMPTY;
        end else begin
          do_pop   = accept;
          r_data   = cd[0];
          cnt_next = CW'(cnt - CW'(1));
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          r_status = STAT_EMPTY;
        end else begin
          r_data = cd[0];
        end
      end
      CMD_SEARCH: r_found = |hits;
      CMD_REPLACE: begin
        if (empty) begin
          r_status = STAT_EMPTY;
        end else begin
          do_load = accept;
        end
      end
      CMD_CLEAR: cnt_next = '0;
      CMD_READ: begin
        if (bad_pos) begin
          r_status = STAT_BADPOS;
        end else begin
          r_data = rd_data;
        end
      end
      CMD_DUMP_UP, CMD_DUMP_DOWN: begin
        if (empty) begin
          r_status = STAT_EMPTY;
        end else begin
          r_data     = rd_data;
          r_last     = dump_last;
          start_dump = accept && !dump_last;
        end
      end
      default: r_status = STAT_OK;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start_dump) state_next = ST_DUMP;
      ST_DUMP: if (dump_emit && dump_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) cnt <= cnt_next;
    end
  end

  // dump beat counter and direction
  always_ff @(posedge clk) begin
    if (start_dump) begin
      k      <= CW'(1);
      dir_up <= (req.command == CMD_DUMP_UP);
    end else if (dump_emit) begin
      k <= CW'(k + CW'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept || dump_emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data   <= r_data;
      out_found  <= r_found;
      out_count  <= CNT_W'(cnt_next);
      out_status <= r_status;
      out_last   <= r_last;
    end else if (dump_emit) begin
      out_data   <= rd_data;
      out_found  <= 1'b0;
      out_count  <= CNT_W'(cnt);
      out_status <= STAT_OK;
      out_last   <= dump_last;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.found  = out_found;
  assign rsp.count  = out_count;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("fill count above depth");

  // the stack does not change while a dump streams out
  a_dump_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |=> $stable(cnt))
    else $error("fill count moved during dump");

  // final dump beat returns the sequencer to idle
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    dump_emit && dump_last |=> state == ST_IDLE)
    else $error("dump did not end after final beat");

  // an accepted push below full grows the stack by one
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    accept && req.command == CMD_PUSH && !full |=> cnt == CW'($past(cnt) + CW'(1)))
    else $error("push did not grow the stack");

  // never two beats at once from decode and dump
  a_one_src: assert property (@(posedge clk) disable iff (rst)
    !(accept && dump_emit))
    else $error("accept during dump");

endmodule

>>> bench/byte_stack_with_search_tb.sv
`timescale 1ns / 1ps

module byte_stack_with_search_tb;
  import bss_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_OFF     = 240;
  localparam int SETTLE_TIME  = 48;
  localparam int ITEM_TARGET  = 410;

  // commands the block does not decode
  localparam logic [CMD_W-1:0] CMD_FIRST_SPARE = CMD_DUMP_DOWN + 1'b1;
  localparam logic [CMD_W-1:0] CMD_LAST_SPARE  = '1;

  typedef struct {
    logic [DATA_W-1:0]   data;
    logic                found;
    logic [CNT_W-1:0]    count;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_beat_t;

  // mirror of the stack plus the queue of beats still owed by the block
  class stack_tracker;
    logic [DATA_W-1:0] cells[STACK_DEPTH];
    int unsigned       depth_used;
    rsp_beat_t         owed_beats[$];
    int unsigned       errors;

    function new();
      depth_used = 0;
      errors     = 0;
    endfunction

    // apply one accepted command and queue the beats it must produce
    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos);
      rsp_beat_t beat;
      int unsigned idx;
      beat.data   = '0;
      beat.found  = 1'b0;
      beat.status = STAT_OK;
      beat.last   = 1'b1;
      case (cmd)
        CMD_PUSH: begin
          if (depth_used >= STACK_DEPTH) begin
            beat.status = STAT_FULL;
          end else begin
            cells[depth_used] = val;
            depth_used++;
          end
        end
        CMD_POP: begin
          if (depth_used == 0) begin
            beat.status = STAT_EMPTY;
          end else begin
            beat.data = cells[depth_used-1];
            depth_used--;
          end
        end
        CMD_PEEK: begin
          if (depth_used == 0) beat.status = STAT_EMPTY;
          else beat.data = cells[depth_used-1];
        end
        CMD_SEARCH: begin
          for (int i = 0; i < depth_used; i++)
            if (cells[i] == val) beat.found = 1'b1;
        end
        CMD_REPLACE: begin
          if (depth_used == 0) beat.status = STAT_EMPTY;
          else cells[depth_used-1] = val;
        end
        CMD_CLEAR: depth_used = 0;
        CMD_READ: begin
          if (pos == 0 || pos > depth_used) beat.status = STAT_BADPOS;
          else beat.data = cells[pos-1];
        end
        CMD_DUMP_UP, CMD_DUMP_DOWN: begin
          if (depth_used == 0) begin
            beat.status = STAT_EMPTY;
          end else begin
            beat.count = depth_used[CNT_W-1:0];
            for (int i = 0; i < depth_used; i++) begin
              idx        = (cmd == CMD_DUMP_UP) ? i : depth_used - 1 - i;
              beat.data  = cells[idx];
              beat.last  = (i + 1 == depth_used);
              owed_beats.push_back(beat);
            end
            return;
          end
        end
        default: ;
      endcase
      beat.count = depth_used[CNT_W-1:0];
      owed_beats.push_back(beat);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    // compare one response beat against the oldest owed beat
    function void check_beat(rsp_beat_t got);
      rsp_beat_t exp_beat;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data=%0d found=%0d",
                 $time, got.data, got.found,
                 " count=%0d status=%0d last=%0d", got.count, got.status, got.last);
        errors++;
        return;
      end
      exp_beat = owed_beats.pop_front();
      compare_field("data", exp_beat.data, got.data);
      compare_field("found", exp_beat.found, got.found);
      compare_field("count", exp_beat.count, got.count);
      compare_field("status", exp_beat.status, got.status);
      compare_field("last", exp_beat.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  bss_req_if   req_ch();
  bss_rsp_if   rsp_ch();

  stack_tracker tracker;
  int unsigned  items_sent;
  int unsigned  idle_cycles;
  bit           steady;
  bit           squeeze_pending;

  byte_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // offer one command beat and wait until the block takes it
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                       input logic [POS_W-1:0] pos);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.value    <= val;
    req_ch.position <= pos;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_command(cmd, val, pos);
    items_sent++;
  endtask

  // a byte that is often already on the stack, so searches can hit
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && tracker.depth_used > 0)
      return tracker.cells[$urandom_range(0, tracker.depth_used - 1)];
    if (r == 4) return '0;
    if (r == 5) return '1;
    return DATA_W'($urandom_range(0, 255));
  endfunction

  // mostly valid positions, some just outside, some anywhere
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8 && tracker.depth_used > 0)
      return POS_W'($urandom_range(1, tracker.depth_used));
    if (r == 8) return ($urandom_range(0, 1) != 0) ? POS_W'(tracker.depth_used + 1) : '0;
    return POS_W'($urandom_range(0, 63));
  endfunction

  task automatic fill_up(input bit to_top);
    int n;
    n = to_top ? STACK_DEPTH - tracker.depth_used + $urandom_range(0, 3)
               : $urandom_range(1, 12);
    repeat (n) offer(CMD_PUSH, pick_value(), '0);
  endtask

  task automatic drain();
    int n;
    n = tracker.depth_used + $urandom_range(0, 1);
    repeat (n) offer(CMD_POP, pick_value(), '0);
  endtask

  task automatic mixed_run(input int n);
    int r;
    logic [CMD_W-1:0] cmd;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 25) cmd = CMD_PUSH;
      else if (r < 40) cmd = CMD_POP;
      else if (r < 48) cmd = CMD_PEEK;
      else if (r < 53) cmd = CMD_COUNT;
      else if (r < 65) cmd = CMD_SEARCH;
      else if (r < 72) cmd = CMD_REPLACE;
      else if (r < 75) cmd = CMD_CLEAR;
      else if (r < 87) cmd = CMD_READ;
      else if (r < 92) cmd = CMD_DUMP_UP;
      else if (r < 97) cmd = CMD_DUMP_DOWN;
      else cmd = CMD_W'($urandom_range(CMD_FIRST_SPARE, CMD_LAST_SPARE));
      offer(cmd, pick_value(), pick_position());
    end
  endtask

  // response side: random stalls, one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (steady || $urandom_range(0, 99) < 65) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  // check every response beat that is taken
  always @(posedge clk) begin
    rsp_beat_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.data   = rsp_ch.data;
      got.found  = rsp_ch.found;
      got.count  = rsp_ch.count;
      got.status = rsp_ch.status;
      got.last   = rsp_ch.last;
      tracker.check_beat(got);
    end
  end

  // cycles without any beat on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit squeezed;
    int kind;
    tracker         = new();
    items_sent      = 0;
    steady          = 1'b0;
    squeeze_pending = 1'b0;
    squeezed        = 1'b0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.command  <= CMD_COUNT;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty stack corners
    offer(CMD_COUNT, 8'h00, 6'd0);
    offer(CMD_POP, 8'h00, 6'd0);
    offer(CMD_PEEK, 8'h00, 6'd0);
    offer(CMD_REPLACE, 8'hFF, 6'd0);
    offer(CMD_DUMP_UP, 8'h00, 6'd0);
    offer(CMD_DUMP_DOWN, 8'h00, 6'd0);
    offer(CMD_SEARCH, 8'h00, 6'd0);
    offer(CMD_READ, 8'h00, 6'd0);
    offer(CMD_READ, 8'h00, 6'd1);
    // a few entries, value and position extremes
    offer(CMD_PUSH, 8'h00, 6'd63);
    offer(CMD_PUSH, 8'hFF, 6'd0);
    offer(CMD_PUSH, 8'hA5, 6'd0);
    offer(CMD_PEEK, 8'h00, 6'd0);
    offer(CMD_SEARCH, 8'hFF, 6'd0);
    offer(CMD_SEARCH, 8'h5A, 6'd0);
    offer(CMD_READ, 8'h00, 6'd1);
    offer(CMD_READ, 8'h00, 6'd3);
    offer(CMD_READ, 8'h00, 6'd4);
    offer(CMD_READ, 8'h00, 6'd63);
    offer(CMD_REPLACE, 8'h5A, 6'd0);
    offer(CMD_DUMP_UP, 8'h00, 6'd0);
    offer(CMD_DUMP_DOWN, 8'h00, 6'd0);
    offer(CMD_POP, 8'h00, 6'd0);
    offer(CMD_LAST_SPARE, 8'hFF, 6'd63);
    offer(CMD_CLEAR, 8'h00, 6'd0);

    // full stack: refused pushes, top position, full dump
    fill_up(1'b1);
    offer(CMD_PUSH, 8'h3C, 6'd0);
    offer(CMD_READ, 8'h00, POS_W'(STACK_DEPTH));
    offer(CMD_SEARCH, pick_value(), 6'd0);
    offer(CMD_DUMP_DOWN, 8'h00, 6'd0);
    offer(CMD_CLEAR, 8'h00, 6'd0);

    // random sequences
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 7) == 0);
      if (!squeezed && items_sent > 150) begin
        squeezed        = 1'b1;
        steady          = 1'b0;
        squeeze_pending = 1'b1;
      end
      kind = $urandom_range(0, 11);
      case (kind)
        0: fill_up(1'b1);
        1, 2: fill_up(1'b0);
        3: drain();
        4: begin
          offer(CMD_DUMP_UP, 8'h00, 6'd0);
          offer(CMD_DUMP_DOWN, 8'h00, 6'd0);
        end
        default: mixed_run($urandom_range(4, 16));
      endcase
    end
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    // wait for owed beats, then watch for strays
    while (tracker.owed_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed_beats.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
